// ===== rtl/polygon_area_and_bounds_defines.svh =====
// assertion helpers shared by the polygon area blocks
`ifndef POLYGON_AREA_AND_BOUNDS_DEFINES_SVH
`define POLYGON_AREA_AND_BOUNDS_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PAB_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PAB_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pab_pkg.sv =====
`timescale 1ns / 1ps

package pab_pkg;

  localparam int COORD_W   = 16;
  localparam int SUM_W     = 44;
  localparam int AREA_W    = SUM_W - 1;
  localparam int PROD_W    = 2 * COORD_W;
  localparam int TERM_W    = PROD_W + 1;
  localparam int EXT_W     = ((SUM_W > TERM_W) ? SUM_W : TERM_W) + 1;
  localparam int MIN_SIDES = 3;
  localparam int SEEN_W    = 2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [TERM_W-1:0]  term_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  // input item
  typedef struct packed {
    coord_t vertex_x;
    coord_t vertex_y;
    logic   last_vertex;
  } vertex_t;

  // result item
  typedef struct packed {
    logic [AREA_W-1:0]  area;
    logic [COORD_W-1:0] box_width;
    logic [COORD_W-1:0] box_height;
    logic               degenerate;
  } result_t;

  // vertex with its neighbors, after the front tracker
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t prev_x;
    coord_t prev_y;
    coord_t first_x;
    coord_t first_y;
    logic   last;
    logic   start;
    logic   degen;
  } front_t;

  // cross-product terms for one vertex
  typedef struct packed {
    coord_t x;
    coord_t y;
    term_t  edge_term;
    term_t  close_term;
    logic   last;
    logic   start;
    logic   degen;
  } cross_t;

  // polygon totals before the closing edge
  typedef struct packed {
    sum_t   sum;
    term_t  close_term;
    coord_t min_x;
    coord_t max_x;
    coord_t min_y;
    coord_t max_y;
    logic   degen;
  } close_t;

  // add a term and clamp to the signed sum range
  function automatic sum_t sat_add(sum_t acc, term_t term);
    logic signed [EXT_W-1:0] wide;
    logic signed [EXT_W-1:0] hi;
    logic signed [EXT_W-1:0] lo;
    wide = EXT_W'(acc) + EXT_W'(term);
    hi   = {{(EXT_W-SUM_W+1){1'b0}}, {(SUM_W-1){1'b1}}};
    lo   = ~hi;
    if (wide > hi) begin
      return sum_t'(hi);
    end else if (wide < lo) begin
      return sum_t'(lo);
    end
    return sum_t'(wide);
  endfunction

endpackage

// ===== rtl/pab_front.sv =====
`timescale 1ns / 1ps
`include "polygon_area_and_bounds_defines.svh"

module pab_front import pab_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  vertex_t in_item,
  output logic    out_valid,
  input  logic    out_ready,
  output front_t  out_item
);

  logic [SEEN_W-1:0] seen;
  logic [SEEN_W-1:0] seen_next;
  coord_t            prev_x;
  coord_t            prev_y;
  coord_t            first_x;
  coord_t            first_y;
  logic              take;
  front_t            item_next;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  // attach previous and first vertex, count vertices
  always_comb begin
    seen_next         = (seen == SEEN_W'(MIN_SIDES)) ? seen : seen + 1'b1;
    item_next.x       = in_item.vertex_x;
    item_next.y       = in_item.vertex_y;
    item_next.prev_x  = prev_x;
    item_next.prev_y  = prev_y;
    item_next.start   = (seen == '0);
    item_next.first_x = item_next.start ? in_item.vertex_x : first_x;
    item_next.first_y = item_next.start ? in_item.vertex_y : first_y;
    item_next.last    = in_item.last_vertex;
    item_next.degen   = seen_next < SEEN_W'(MIN_SIDES);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      seen      <= '0;
      prev_x    <= '0;
      prev_y    <= '0;
      first_x   <= '0;
      first_y   <= '0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (take) begin
        seen    <= in_item.last_vertex ? '0 : seen_next;
        prev_x  <= in_item.vertex_x;
        prev_y  <= in_item.vertex_y;
        first_x <= item_next.first_x;
        first_y <= item_next.first_y;
      end
    end
    if (take) begin
      out_item <= item_next;
    end
  end

  `PAB_ASSERT_NEXT(a_new_polygon, take && in_item.last_vertex, seen == '0, "count not cleared")
  `PAB_ASSERT_IMPL(a_start_self, out_valid && out_item.start, out_item.degen && out_item.first_x == out_item.x && out_item.first_y == out_item.y, "bad start vertex")
  `PAB_ASSERT_NEXT(a_stage_hold, out_valid && !out_ready, out_valid && $stable(out_item), "stalled item moved")

endmodule

// ===== rtl/pab_cross.sv =====
`timescale 1ns / 1ps

module pab_cross import pab_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  front_t in_item,
  output logic   out_valid,
  input  logic   out_ready,
  output cross_t out_item
);

  typedef struct packed {
    coord_t x;
    coord_t y;
    prod_t  edge_a;
    prod_t  edge_b;
    prod_t  close_a;
    prod_t  close_b;
    logic   last;
    logic   start;
    logic   degen;
  } prod_stage_t;

  logic        prod_valid;
  logic        prod_free;
  logic        term_free;
  prod_stage_t prod_item;
  prod_stage_t prod_next;
  cross_t      term_next;

  assign term_free = !out_valid || out_ready;
  assign prod_free = !prod_valid || term_free;
  assign in_ready  = prod_free;

  // four independent products
  always_comb begin
    prod_next.x       = in_item.x;
    prod_next.y       = in_item.y;
    prod_next.edge_a  = in_item.prev_x * in_item.y;
    prod_next.edge_b  = in_item.x * in_item.prev_y;
    prod_next.close_a = in_item.x * in_item.first_y;
    prod_next.close_b = in_item.first_x * in_item.y;
    prod_next.last    = in_item.last;
    prod_next.start   = in_item.start;
    prod_next.degen   = in_item.degen;
  end

  // cross terms; no edge term on a first vertex, closing term only on a last one
  always_comb begin
    term_next.x          = prod_item.x;
    term_next.y          = prod_item.y;
    term_next.edge_term  = prod_item.start ? '0 :
                           term_t'(prod_item.edge_a) - term_t'(prod_item.edge_b);
    term_next.close_term = prod_item.last ?
                           term_t'(prod_item.close_a) - term_t'(prod_item.close_b) : '0;
    term_next.last       = prod_item.last;
    term_next.start      = prod_item.start;
    term_next.degen      = prod_item.degen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (prod_free) begin
        prod_valid <= in_valid;
      end
      if (term_free) begin
        out_valid <= prod_valid;
      end
    end
    if (in_valid && prod_free) begin
      prod_item <= prod_next;
    end
    if (prod_valid && term_free) begin
      out_item <= term_next;
    end
  end

endmodule

// ===== rtl/pab_accum.sv =====
`timescale 1ns / 1ps

module pab_accum import pab_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  cross_t in_item,
  output logic   out_valid,
  input  logic   out_ready,
  output close_t out_item
);

  sum_t   cross_sum;
  coord_t min_x;
  coord_t max_x;
  coord_t min_y;
  coord_t max_y;
  logic   out_free;
  logic   take;
  close_t close_next;

  // only last vertices need room downstream
  assign out_free = !out_valid || out_ready;
  assign in_ready = !in_item.last || out_free;
  assign take     = in_valid && in_ready;

  // running sum and bounds, restarted on a first vertex
  always_comb begin
    close_next.sum        = sat_add(in_item.start ? '0 : cross_sum, in_item.edge_term);
    close_next.close_term = in_item.close_term;
    close_next.min_x      = (in_item.start || in_item.x < min_x) ? in_item.x : min_x;
    close_next.max_x      = (in_item.start || in_item.x > max_x) ? in_item.x : max_x;
    close_next.min_y      = (in_item.start || in_item.y < min_y) ? in_item.y : min_y;
    close_next.max_y      = (in_item.start || in_item.y > max_y) ? in_item.y : max_y;
    close_next.degen      = in_item.degen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cross_sum <= '0;
      min_x     <= '0;
      max_x     <= '0;
      min_y     <= '0;
      max_y     <= '0;
    end else begin
      if (out_free) begin
        out_valid <= in_valid && in_item.last;
      end
      if (take) begin
        cross_sum <= close_next.sum;
        min_x     <= close_next.min_x;
        max_x     <= close_next.max_x;
        min_y     <= close_next.min_y;
        max_y     <= close_next.max_y;
      end
    end
    if (take && in_item.last) begin
      out_item <= close_next;
    end
  end

endmodule

// ===== rtl/pab_result.sv =====
`timescale 1ns / 1ps
`include "polygon_area_and_bounds_defines.svh"

module pab_result import pab_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  close_t  in_item,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_item
);

  typedef struct packed {
    sum_t               sum;
    logic [COORD_W-1:0] box_width;
    logic [COORD_W-1:0] box_height;
    logic               degen;
  } final_t;

  localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // magnitude of the sum, most negative value clamps to the top
  function automatic logic [AREA_W-1:0] sat_abs(sum_t s);
    sum_t neg;
    neg = -s;
    if (s == SUM_MIN) begin
      return '1;
    end else if (s[SUM_W-1]) begin
      return neg[AREA_W-1:0];
    end
    return s[AREA_W-1:0];
  endfunction

  logic    fin_valid;
  logic    fin_free;
  logic    out_free;
  final_t  fin_item;
  final_t  fin_next;
  result_t res_next;

  assign out_free = !out_valid || out_ready;
  assign fin_free = !fin_valid || out_free;
  assign in_ready = fin_free;

  // closing edge and box size
  always_comb begin
    fin_next.sum        = sat_add(in_item.sum, in_item.close_term);
    fin_next.box_width  = in_item.max_x - in_item.min_x;
    fin_next.box_height = in_item.max_y - in_item.min_y;
    fin_next.degen      = in_item.degen;
  end

  // area, forced to zero on short polygons
  always_comb begin
    res_next.area       = fin_item.degen ? '0 : sat_abs(fin_item.sum);
    res_next.box_width  = fin_item.box_width;
    res_next.box_height = fin_item.box_height;
    res_next.degenerate = fin_item.degen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (fin_free) begin
        fin_valid <= in_valid;
      end
      if (out_free) begin
        out_valid <= fin_valid;
      end
    end
    if (in_valid && fin_free) begin
      fin_item <= fin_next;
    end
    if (fin_valid && out_free) begin
      out_item <= res_next;
    end
  end

  `PAB_ASSERT_IMPL(a_degen_zero, out_valid && out_item.degenerate, out_item.area == '0, "degenerate with area")
  `PAB_ASSERT_NEXT(a_degen_carry, fin_valid && out_free, out_valid && out_item.degenerate == $past(fin_item.degen), "flag lost")
  `PAB_ASSERT_NEXT(a_fin_hold, fin_valid && !out_free, fin_valid && $stable(fin_item), "stalled total moved")

endmodule

// ===== rtl/polygon_area_and_bounds.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake                    payload
// vertex    in         vertex_valid / vertex_ready  vertex_t: x, y, last flag
// result    out        result_valid / result_ready  result_t: area, box, degenerate
//
// one vertex per cycle, sustained while results are taken; the four
// multiplies share the product stage, the saturating accumulate its own stage
// a result follows its polygon's last vertex through front, cross, accum, result
// synchronous reset clears all valid flags and the running sum and bounds
// a stalled result holds; vertices keep flowing until the stages behind it fill

module polygon_area_and_bounds import pab_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    vertex_valid,
  output logic    vertex_ready,
  input  vertex_t vertex,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  logic   front_valid;
  logic   front_ready;
  front_t front_item;
  logic   cross_valid;
  logic   cross_ready;
  cross_t cross_item;
  logic   close_valid;
  logic   close_ready;
  close_t close_item;

  // previous and first vertex tracking
  pab_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vertex_valid),
    .in_ready  (vertex_ready),
    .in_item   (vertex),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_item  (front_item)
  );

  // cross products
  pab_cross u_cross (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_item   (front_item),
    .out_valid (cross_valid),
    .out_ready (cross_ready),
    .out_item  (cross_item)
  );

  // running sum and bounds
  pab_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cross_valid),
    .in_ready  (cross_ready),
    .in_item   (cross_item),
    .out_valid (close_valid),
    .out_ready (close_ready),
    .out_item  (close_item)
  );

  // closing edge, magnitude and output register
  pab_result u_result (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (close_valid),
    .in_ready  (close_ready),
    .in_item   (close_item),
    .out_valid (result_valid),
    .out_ready (result_ready),
    .out_item  (result)
  );

endmodule
